### design/mppt_popi_pkg.sv
// ----------------------------------------------------------------------------
// mppt_popi_pkg
// shared types, register indexes, reset values and the sequencer microprogram
// for the perturb-and-observe tracker with its pi voltage loop
// ----------------------------------------------------------------------------
package mppt_popi_pkg;

    // register file
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_UPDATE_PERIOD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOWER_WINDOW  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER_WINDOW  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COARSE_STEP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FINE_STEP     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROP_GAIN     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_INT_GAIN      = 3'd6;

    // register reset values (0.66 * 23.8 V, 0.94 * 23.8 V, 1 V, 0.15 V, 0.0380)
    localparam logic [CFG_DATA_W-1:0] RST_UPDATE_PERIOD = 16'd1;
    localparam logic [CFG_DATA_W-1:0] RST_LOWER_WINDOW  = 16'd16085;
    localparam logic [CFG_DATA_W-1:0] RST_UPPER_WINDOW  = 16'd22909;
    localparam logic [CFG_DATA_W-1:0] RST_COARSE_STEP   = 16'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_FINE_STEP     = 16'd154;
    localparam logic [CFG_DATA_W-1:0] RST_PROP_GAIN     = 16'd2490;
    localparam logic [CFG_DATA_W-1:0] RST_INT_GAIN      = 16'd2490;

    // payload widths
    localparam int VOLT_W  = 16;
    localparam int DUTY_W  = 24;
    localparam int ERR_W   = 17;
    localparam int POWER_W = 32;
    localparam int INTEG_W = 32;

    // shared multiplier: 17-bit signed by 33-bit signed
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 1;

    // sequencer
    localparam int STEP_W    = 3;
    localparam int NUM_STEPS = 8;
    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_REF    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_FINISH = 3'd7;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_POWER,
        MUL_INT_ERR,
        MUL_INT_INTEG,
        MUL_PROP_ERR
    } t_mul_sel;

    // datapath operation of a step
    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_LOAD_IN,
        ALU_REF,
        ALU_INTEG,
        ALU_ACC,
        ALU_DUTY
    } t_alu_op;

    // handshake that a step waits on
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } t_wait_on;

    // one control word
    typedef struct packed {
        t_mul_sel          mul_sel;
        t_alu_op           alu_op;
        t_wait_on          wait_on;
        logic              jump;
        logic [STEP_W-1:0] target;
    } t_ucode;

    // microprogram, one word per step
    localparam t_ucode UCODE [NUM_STEPS] = '{
        // 0: take the tick transaction
        '{MUL_NONE,      ALU_LOAD_IN, WAIT_IN,   1'b0, STEP_IDLE},
        // 1: power = voltage * current
        '{MUL_POWER,     ALU_NOP,     WAIT_NONE, 1'b0, STEP_IDLE},
        // 2: perturb-and-observe update, tick phase, error
        '{MUL_NONE,      ALU_REF,     WAIT_NONE, 1'b0, STEP_IDLE},
        // 3: int_gain * error
        '{MUL_INT_ERR,   ALU_NOP,     WAIT_NONE, 1'b0, STEP_IDLE},
        // 4: integrator update
        '{MUL_NONE,      ALU_INTEG,   WAIT_NONE, 1'b0, STEP_IDLE},
        // 5: int_gain * integrator
        '{MUL_INT_INTEG, ALU_NOP,     WAIT_NONE, 1'b0, STEP_IDLE},
        // 6: park the integral term, prop_gain * error
        '{MUL_PROP_ERR,  ALU_ACC,     WAIT_NONE, 1'b0, STEP_IDLE},
        // 7: round, saturate, load the result register, back to idle
        '{MUL_NONE,      ALU_DUTY,    WAIT_OUT,  1'b1, STEP_IDLE}
    };

endpackage

### design/mppt_perturb_observe_pi.sv
// ----------------------------------------------------------------------------
// mppt_perturb_observe_pi
// windowed perturb-and-observe mppt with a pi voltage loop, run by a small
// microcoded sequencer around one shared multiplier
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) carries one control tick: panel
//   voltage and current, unsigned q6.10. every update_period-th tick, starting
//   with the first after reset, the reference voltage is perturbed; every
//   tick the pi stage produces one result transaction on the output channel
//   (o_out_valid / i_out_ready): duty command, voltage error, reference.
//   the result register is loaded at the final step of the eight-step
//   microprogram, which runs four products through the single 17x33 multiplier.
//   the input is taken only while the sequencer sits at its idle step; a
//   result waiting in the output register does not block the next input.
//   if the receiver stalls, the sequencer holds at its final step until the
//   output register frees up, then loads it and returns to idle.
//   reset (synchronous, active low) restores the register defaults and clears
//   the tick phase, stored power and voltage, reference and integrator.
//   configuration writes (i_cfg_we, i_cfg_addr, i_cfg_wdata) take effect at
//   once; indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module mppt_perturb_observe_pi (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [mppt_popi_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [mppt_popi_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // tick input
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [mppt_popi_pkg::VOLT_W-1:0]      i_panel_voltage,
    input  logic [mppt_popi_pkg::VOLT_W-1:0]      i_panel_current,
    // result output
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [mppt_popi_pkg::DUTY_W-1:0] o_duty_command,
    output logic signed [mppt_popi_pkg::ERR_W-1:0]  o_voltage_error,
    output logic [mppt_popi_pkg::VOLT_W-1:0]      o_voltage_reference
);

    localparam int VW = mppt_popi_pkg::VOLT_W;
    localparam int PW = mppt_popi_pkg::PROD_W;
    localparam int SW = mppt_popi_pkg::SUM_W;

    // configuration registers
    logic [VW-1:0] r_update_period, r_lower_window, r_upper_window;
    logic [VW-1:0] r_coarse_step, r_fine_step, r_prop_gain, r_int_gain;

    // sequencer and datapath registers
    logic [mppt_popi_pkg::STEP_W-1:0]         r_step, n_step;
    logic [VW-1:0]                            r_volt, r_curr;
    logic signed [PW-1:0]                     r_prod, r_acc;
    logic signed [mppt_popi_pkg::ERR_W-1:0]   r_err, n_err;
    logic [VW-1:0]                            r_phase, n_phase;
    logic [VW-1:0]                            r_ref, n_ref;
    logic [mppt_popi_pkg::POWER_W-1:0]        r_last_power;
    logic [VW-1:0]                            r_last_volt;
    logic signed [mppt_popi_pkg::INTEG_W-1:0] r_integ, n_integ;
    logic signed [mppt_popi_pkg::DUTY_W-1:0]  n_duty;
    logic                                     r_out_valid;
    logic signed [mppt_popi_pkg::DUTY_W-1:0]  r_duty;
    logic signed [mppt_popi_pkg::ERR_W-1:0]   r_out_err;
    logic [VW-1:0]                            r_out_ref;

    // control word of the current step
    mppt_popi_pkg::t_ucode ctl;
    logic                  stall;
    logic                  run;

    assign ctl   = mppt_popi_pkg::UCODE[r_step];
    assign stall = (ctl.wait_on == mppt_popi_pkg::WAIT_IN && !i_in_valid)
                || (ctl.wait_on == mppt_popi_pkg::WAIT_OUT && r_out_valid && !i_out_ready);
    assign run   = !stall;

    // step counter: hold on a wait, jump or fall through
    always_comb begin
        if (stall) begin
            n_step = r_step;
        end else if (ctl.jump) begin
            n_step = ctl.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    // shared multiplier operand selection
    logic signed [mppt_popi_pkg::MUL_A_W-1:0] mul_a;
    logic signed [mppt_popi_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]                     mul_p;

    always_comb begin
        case (ctl.mul_sel)
            mppt_popi_pkg::MUL_POWER: begin
                mul_a = $signed({1'b0, r_volt});
                mul_b = $signed({17'd0, r_curr});
            end
            mppt_popi_pkg::MUL_INT_ERR: begin
                mul_a = $signed({1'b0, r_int_gain});
                mul_b = mppt_popi_pkg::MUL_B_W'(r_err);
            end
            mppt_popi_pkg::MUL_INT_INTEG: begin
                mul_a = $signed({1'b0, r_int_gain});
                mul_b = mppt_popi_pkg::MUL_B_W'(r_integ);
            end
            mppt_popi_pkg::MUL_PROP_ERR: begin
                mul_a = $signed({1'b0, r_prop_gain});
                mul_b = mppt_popi_pkg::MUL_B_W'(r_err);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // perturb-and-observe reference update
    logic signed [VW+1:0]              ref_base, ref_sum;
    logic                              power_up;
    logic                              volt_up;
    logic [mppt_popi_pkg::POWER_W-1:0] power;

    assign power    = r_prod[mppt_popi_pkg::POWER_W-1:0];
    assign power_up = power >= r_last_power;
    assign volt_up  = r_volt > r_last_volt;
    assign ref_base = $signed({2'b00, r_ref});

    always_comb begin
        if (r_volt < r_lower_window) begin
            ref_sum = ref_base + $signed({2'b00, r_coarse_step});
        end else if (r_volt > r_upper_window) begin
            ref_sum = ref_base - $signed({2'b00, r_coarse_step});
        end else if (power_up == volt_up) begin
            ref_sum = ref_base + $signed({2'b00, r_fine_step});
        end else begin
            ref_sum = ref_base - $signed({2'b00, r_fine_step});
        end
        if (r_phase != '0) begin
            n_ref = r_ref;
        end else if (ref_sum[VW+1]) begin
            n_ref = '0;
        end else if (ref_sum[VW]) begin
            n_ref = '1;
        end else begin
            n_ref = ref_sum[VW-1:0];
        end
    end

    assign n_err = $signed({1'b0, r_volt}) - $signed({1'b0, n_ref});

    // tick phase, a zero period counts as one
    logic [VW-1:0] phase_inc;
    logic [VW-1:0] period;

    assign phase_inc = r_phase + 1'b1;
    assign period    = (r_update_period == '0) ? VW'(1) : r_update_period;
    assign n_phase   = (phase_inc >= period) ? '0 : phase_inc;

    // integrator: add the rounded increment, saturate to 32 bits
    logic signed [PW-1:0] ie_rnd;
    logic signed [SW-1:0] integ_sum;

    assign ie_rnd    = (r_prod + PW'(32768)) >>> 16;
    assign integ_sum = SW'(r_integ) + SW'(ie_rnd);

    always_comb begin
        if (&integ_sum[SW-1:mppt_popi_pkg::INTEG_W-1]
                || ~|integ_sum[SW-1:mppt_popi_pkg::INTEG_W-1]) begin
            n_integ = integ_sum[mppt_popi_pkg::INTEG_W-1:0];
        end else if (integ_sum[SW-1]) begin
            n_integ = {1'b1, {(mppt_popi_pkg::INTEG_W-1){1'b0}}};
        end else begin
            n_integ = {1'b0, {(mppt_popi_pkg::INTEG_W-1){1'b1}}};
        end
    end

    // duty command: round the sum of both terms, saturate to 24 bits
    logic signed [SW-1:0] duty_sum, duty_rnd;

    assign duty_sum = SW'(r_acc) + SW'(r_prod) + SW'(32768);
    assign duty_rnd = duty_sum >>> 16;

    always_comb begin
        if (&duty_rnd[SW-1:mppt_popi_pkg::DUTY_W-1]
                || ~|duty_rnd[SW-1:mppt_popi_pkg::DUTY_W-1]) begin
            n_duty = duty_rnd[mppt_popi_pkg::DUTY_W-1:0];
        end else if (duty_rnd[SW-1]) begin
            n_duty = {1'b1, {(mppt_popi_pkg::DUTY_W-1){1'b0}}};
        end else begin
            n_duty = {1'b0, {(mppt_popi_pkg::DUTY_W-1){1'b1}}};
        end
    end

    // sequencer state, datapath, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step          <= mppt_popi_pkg::STEP_IDLE;
            r_out_valid     <= 1'b0;
            r_phase         <= '0;
            r_ref           <= '0;
            r_last_power    <= '0;
            r_last_volt     <= '0;
            r_integ         <= '0;
            r_update_period <= mppt_popi_pkg::RST_UPDATE_PERIOD;
            r_lower_window  <= mppt_popi_pkg::RST_LOWER_WINDOW;
            r_upper_window  <= mppt_popi_pkg::RST_UPPER_WINDOW;
            r_coarse_step   <= mppt_popi_pkg::RST_COARSE_STEP;
            r_fine_step     <= mppt_popi_pkg::RST_FINE_STEP;
            r_prop_gain     <= mppt_popi_pkg::RST_PROP_GAIN;
            r_int_gain      <= mppt_popi_pkg::RST_INT_GAIN;
        end else begin
            r_step <= n_step;

            // configuration write
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    mppt_popi_pkg::CFG_UPDATE_PERIOD: r_update_period <= i_cfg_wdata;
                    mppt_popi_pkg::CFG_LOWER_WINDOW:  r_lower_window  <= i_cfg_wdata;
                    mppt_popi_pkg::CFG_UPPER_WINDOW:  r_upper_window  <= i_cfg_wdata;
                    mppt_popi_pkg::CFG_COARSE_STEP:   r_coarse_step   <= i_cfg_wdata;
                    mppt_popi_pkg::CFG_FINE_STEP:     r_fine_step     <= i_cfg_wdata;
                    mppt_popi_pkg::CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_wdata;
                    mppt_popi_pkg::CFG_INT_GAIN:      r_int_gain      <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // result register fills at the final step, drains on the output transaction
            if (run && ctl.alu_op == mppt_popi_pkg::ALU_DUTY) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // product register
            if (ctl.mul_sel != mppt_popi_pkg::MUL_NONE) begin
                r_prod <= mul_p;
            end

            // datapath operation of this step
            if (run) begin
                case (ctl.alu_op)
                    mppt_popi_pkg::ALU_LOAD_IN: begin
                        r_volt <= i_panel_voltage;
                        r_curr <= i_panel_current;
                    end
                    mppt_popi_pkg::ALU_REF: begin
                        if (r_phase == '0) begin
                            r_last_power <= power;
                            r_last_volt  <= r_volt;
                        end
                        r_ref   <= n_ref;
                        r_phase <= n_phase;
                        r_err   <= n_err;
                    end
                    mppt_popi_pkg::ALU_INTEG: begin
                        r_integ <= n_integ;
                    end
                    mppt_popi_pkg::ALU_ACC: begin
                        r_acc <= r_prod;
                    end
                    mppt_popi_pkg::ALU_DUTY: begin
                        r_duty    <= n_duty;
                        r_out_err <= r_err;
                        r_out_ref <= r_ref;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_in_ready          = (ctl.wait_on == mppt_popi_pkg::WAIT_IN);
    assign o_out_valid         = r_out_valid;
    assign o_duty_command      = r_duty;
    assign o_voltage_error     = r_out_err;
    assign o_voltage_reference = r_out_ref;

    // an accepted tick starts the microprogram
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_step == mppt_popi_pkg::STEP_IDLE + 1'b1))
        else $error("sequencer did not start after input transaction");

    // a stalled receiver holds the sequencer at its final step
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == mppt_popi_pkg::STEP_FINISH && r_out_valid && !i_out_ready)
        |=> (r_step == mppt_popi_pkg::STEP_FINISH))
        else $error("sequencer left the final step while the result was stalled");

    // a loaded result carries the reference of its own tick
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == mppt_popi_pkg::STEP_FINISH && !(r_out_valid && !i_out_ready))
        |=> (r_out_valid && o_voltage_reference == r_ref))
        else $error("result register not loaded with the current reference");

    // the input is never taken mid-program
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != mppt_popi_pkg::STEP_IDLE) |-> !o_in_ready)
        else $error("input ready while the microprogram runs");

endmodule

### sim/tb_mppt_perturb_observe_pi.sv
// ----------------------------------------------------------------------------
// tb_mppt_perturb_observe_pi
// self-checking bench for the perturb-and-observe tracker with pi voltage loop:
// a bit-true predictor of reference, integrator and duty runs beside the block,
// fed by directed ticks, a sweep of the duty command across both rails and
// randomized tracking phases, with random gaps on the tick channel and random
// stalls on the result channel
// ----------------------------------------------------------------------------
module tb_mppt_perturb_observe_pi;
    timeunit 1ns;
    timeprecision 1ps;

    // index with no register behind it
    localparam logic [mppt_popi_pkg::CFG_ADDR_W-1:0] CFG_UNMAPPED = 3'd7;

    // saturation rails
    localparam longint INTEG_HI = 64'sd2147483647;
    localparam longint INTEG_LO = -64'sd2147483648;
    localparam longint DUTY_HI  = 64'sd8388607;
    localparam longint DUTY_LO  = -64'sd8388608;
    localparam longint VREF_HI  = 64'sd65535;

    // panel curve used to keep the voltage near the reference
    localparam int KNEE_V = 19500;
    localparam int OPEN_V = 24400;

    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_TICKS    = 216;
    localparam int SAT_UP_TICKS   = 140;
    localparam int SAT_DOWN_TICKS = 280;

    typedef struct {
        logic signed [mppt_popi_pkg::DUTY_W-1:0] duty;
        logic signed [mppt_popi_pkg::ERR_W-1:0]  verr;
        logic [mppt_popi_pkg::VOLT_W-1:0]        vref;
    } t_tick_result;

    logic                                    i_clk;
    logic                                    i_rst_n;
    logic                                    i_cfg_we;
    logic [mppt_popi_pkg::CFG_ADDR_W-1:0]    i_cfg_addr;
    logic [mppt_popi_pkg::CFG_DATA_W-1:0]    i_cfg_wdata;
    logic                                    i_in_valid;
    logic                                    o_in_ready;
    logic [mppt_popi_pkg::VOLT_W-1:0]        i_panel_voltage;
    logic [mppt_popi_pkg::VOLT_W-1:0]        i_panel_current;
    logic                                    o_out_valid;
    logic                                    i_out_ready;
    logic signed [mppt_popi_pkg::DUTY_W-1:0] o_duty_command;
    logic signed [mppt_popi_pkg::ERR_W-1:0]  o_voltage_error;
    logic [mppt_popi_pkg::VOLT_W-1:0]        o_voltage_reference;

    // register shadow
    logic [15:0] reg_period, reg_lower, reg_upper, reg_coarse, reg_fine;
    logic [15:0] reg_kp, reg_ki;

    // tracker and pi state
    logic [15:0]        trk_phase;
    logic [31:0]        trk_last_power;
    logic [15:0]        trk_last_volt;
    logic [15:0]        trk_reference;
    logic signed [31:0] pi_integrator;

    t_tick_result pending_pi_results[$];
    int           mismatch_count;
    bit           gaps_enabled;

    mppt_perturb_observe_pi uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_panel_voltage     (i_panel_voltage),
        .i_panel_current     (i_panel_current),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_duty_command      (o_duty_command),
        .o_voltage_error     (o_voltage_error),
        .o_voltage_reference (o_voltage_reference)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // add half an lsb, then floor
    function automatic longint round_q16(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    // one control tick: perturb-and-observe update, then the pi stage
    function automatic t_tick_result step_tracker(input logic [15:0] volt,
                                                  input logic [15:0] amps);
        logic [31:0]  power;
        logic [15:0]  period;
        logic         rising;
        longint       next_ref, verr, integ, duty;
        t_tick_result res;
        period = (reg_period == 16'd0) ? 16'd1 : reg_period;
        if (trk_phase == 16'd0) begin
            power    = volt * amps;
            next_ref = longint'(trk_reference);
            if (volt < reg_lower) begin
                next_ref = next_ref + longint'(reg_coarse);
            end else if (volt > reg_upper) begin
                next_ref = next_ref - longint'(reg_coarse);
            end else begin
                // equal power counts as raised, equal voltage as not raised
                rising = (power >= trk_last_power) == (volt > trk_last_volt);
                if (rising)
                    next_ref = next_ref + longint'(reg_fine);
                else
                    next_ref = next_ref - longint'(reg_fine);
            end
            trk_reference  = 16'(clamp(next_ref, 0, VREF_HI));
            trk_last_power = power;
            trk_last_volt  = volt;
        end
        trk_phase = trk_phase + 16'd1;
        if (trk_phase >= period)
            trk_phase = 16'd0;

        // pi stage, int_gain used on the increment and on the integrator
        verr  = longint'(volt) - longint'(trk_reference);
        integ = longint'(pi_integrator) + round_q16(longint'(reg_ki) * verr);
        integ = clamp(integ, INTEG_LO, INTEG_HI);
        pi_integrator = 32'(integ);
        duty = round_q16(longint'(reg_kp) * verr + longint'(reg_ki) * integ);
        duty = clamp(duty, DUTY_LO, DUTY_HI);
        res.duty = duty[mppt_popi_pkg::DUTY_W-1:0];
        res.verr = verr[mppt_popi_pkg::ERR_W-1:0];
        res.vref = trk_reference;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // register write, block must be idle
    task automatic write_reg(input logic [mppt_popi_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            mppt_popi_pkg::CFG_UPDATE_PERIOD: reg_period = val;
            mppt_popi_pkg::CFG_LOWER_WINDOW:  reg_lower  = val;
            mppt_popi_pkg::CFG_UPPER_WINDOW:  reg_upper  = val;
            mppt_popi_pkg::CFG_COARSE_STEP:   reg_coarse = val;
            mppt_popi_pkg::CFG_FINE_STEP:     reg_fine   = val;
            mppt_popi_pkg::CFG_PROP_GAIN:     reg_kp     = val;
            mppt_popi_pkg::CFG_INT_GAIN:      reg_ki     = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] period, lower, upper, coarse,
                                  input logic [15:0] fine, kp, ki);
        write_reg(mppt_popi_pkg::CFG_UPDATE_PERIOD, period);
        write_reg(mppt_popi_pkg::CFG_LOWER_WINDOW, lower);
        write_reg(mppt_popi_pkg::CFG_UPPER_WINDOW, upper);
        write_reg(mppt_popi_pkg::CFG_COARSE_STEP, coarse);
        write_reg(mppt_popi_pkg::CFG_FINE_STEP, fine);
        write_reg(mppt_popi_pkg::CFG_PROP_GAIN, kp);
        write_reg(mppt_popi_pkg::CFG_INT_GAIN, ki);
    endtask

    // send one tick transaction and queue its expected result
    task automatic send_tick(input logic [15:0] volt, input logic [15:0] amps);
        int gap;
        gap = gaps_enabled ? $urandom_range(0, 8) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_panel_voltage <= volt;
        i_panel_current <= amps;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        pending_pi_results.push_back(step_tracker(volt, amps));
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_pi_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------

    // reset defaults: both coarse branches, window edges, fine steps and ties
    task automatic test_reset_defaults();
        send_tick(16'd0, 16'd0);
        send_tick(16'd16085, 16'd4000);
        send_tick(16'd16085, 16'd4000);
        send_tick(16'd22909, 16'd3000);
        send_tick(16'd20000, 16'd4000);
        send_tick(16'd21000, 16'd100);
        send_tick(16'd65535, 16'd65535);
        send_tick(16'd1, 16'd65535);
    endtask

    // reference pinned at both rails by coarse steps and at the lower rail by fine steps
    task automatic test_reference_limits();
        settle();
        write_reg(mppt_popi_pkg::CFG_COARSE_STEP, 16'hFFFF);
        write_reg(mppt_popi_pkg::CFG_FINE_STEP, 16'hFFFF);
        send_tick(16'd0, 16'd1);
        send_tick(16'd0, 16'd1);
        send_tick(16'd65535, 16'd1);
        send_tick(16'd65535, 16'd1);
        settle();
        write_reg(mppt_popi_pkg::CFG_LOWER_WINDOW, 16'd0);
        write_reg(mppt_popi_pkg::CFG_UPPER_WINDOW, 16'hFFFF);
        send_tick(16'd30000, 16'd5000);
        send_tick(16'd30000, 16'd5000);
    endtask

    // update period of zero, lowered below the phase, largest, unmapped index
    task automatic test_update_period();
        settle();
        apply_settings(16'd0, mppt_popi_pkg::RST_LOWER_WINDOW,
                       mppt_popi_pkg::RST_UPPER_WINDOW, mppt_popi_pkg::RST_COARSE_STEP,
                       mppt_popi_pkg::RST_FINE_STEP, mppt_popi_pkg::RST_PROP_GAIN,
                       mppt_popi_pkg::RST_INT_GAIN);
        send_tick(16'd10000, 16'd2000);
        send_tick(16'd10000, 16'd2000);
        settle();
        write_reg(mppt_popi_pkg::CFG_UPDATE_PERIOD, 16'd5);
        send_tick(16'd12000, 16'd2000);
        send_tick(16'd12000, 16'd2000);
        send_tick(16'd12000, 16'd2000);
        settle();
        write_reg(mppt_popi_pkg::CFG_UPDATE_PERIOD, 16'd2);
        send_tick(16'd12000, 16'd2000);
        send_tick(16'd12000, 16'd2000);
        settle();
        write_reg(mppt_popi_pkg::CFG_UPDATE_PERIOD, 16'hFFFF);
        send_tick(16'd30000, 16'd1000);
        send_tick(16'd30000, 16'd1000);
        settle();
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        send_tick(16'd8000, 16'd1000);
    endtask

    // zero and full-scale gains
    task automatic test_gain_extremes();
        settle();
        apply_settings(16'd1, mppt_popi_pkg::RST_LOWER_WINDOW,
                       mppt_popi_pkg::RST_UPPER_WINDOW, mppt_popi_pkg::RST_COARSE_STEP,
                       mppt_popi_pkg::RST_FINE_STEP, 16'd0, 16'd0);
        send_tick(16'd65535, 16'hAAAA);
        send_tick(16'd0, 16'h5555);
        settle();
        write_reg(mppt_popi_pkg::CFG_PROP_GAIN, 16'hFFFF);
        write_reg(mppt_popi_pkg::CFG_INT_GAIN, 16'hFFFF);
        send_tick(16'd65535, 16'd0);
        send_tick(16'd0, 16'd65535);
    endtask

    // push the duty command onto its upper rail, then across to the lower one
    task automatic test_duty_saturation();
        settle();
        gaps_enabled = 1'b0;
        apply_settings(16'd1, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        repeat (SAT_UP_TICKS) send_tick(16'd65535, 16'($urandom_range(0, 65535)));
        settle();
        write_reg(mppt_popi_pkg::CFG_LOWER_WINDOW, 16'hFFFF);
        repeat (SAT_DOWN_TICKS) send_tick(16'd0, 16'($urandom_range(0, 65535)));
    endtask

    // randomized phases: mostly a panel following the reference, some noise
    task automatic test_random_tracking();
        int vi, ci, isc;
        logic [15:0] lo, hi, coarse, fine;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            gaps_enabled = ($urandom_range(0, 3) != 0);
            isc = $urandom_range(3000, 9000);
            if (ph == 0) begin
                apply_settings(mppt_popi_pkg::RST_UPDATE_PERIOD,
                               mppt_popi_pkg::RST_LOWER_WINDOW,
                               mppt_popi_pkg::RST_UPPER_WINDOW,
                               mppt_popi_pkg::RST_COARSE_STEP,
                               mppt_popi_pkg::RST_FINE_STEP,
                               mppt_popi_pkg::RST_PROP_GAIN,
                               mppt_popi_pkg::RST_INT_GAIN);
            end else if (ph == 1) begin
                apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            end else if (ph == 2) begin
                apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF);
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    lo = 16'($urandom_range(0, 65535));
                    hi = 16'($urandom_range(0, 65535));
                end else begin
                    lo = 16'($urandom_range(12000, 20000));
                    hi = 16'(int'(lo) + $urandom_range(0, 8000));
                end
                coarse = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 2048));
                fine   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 512));
                case ($urandom_range(0, 4))
                    0: write_reg(mppt_popi_pkg::CFG_UPDATE_PERIOD, 16'd0);
                    1: write_reg(mppt_popi_pkg::CFG_UPDATE_PERIOD,
                                 16'($urandom_range(2, 4)));
                    2: write_reg(mppt_popi_pkg::CFG_UPDATE_PERIOD,
                                 16'($urandom_range(5, 20)));
                    3: write_reg(mppt_popi_pkg::CFG_UPDATE_PERIOD,
                                 16'($urandom_range(1, 65535)));
                    default: write_reg(mppt_popi_pkg::CFG_UPDATE_PERIOD, 16'd1);
                endcase
                write_reg(mppt_popi_pkg::CFG_LOWER_WINDOW, lo);
                write_reg(mppt_popi_pkg::CFG_UPPER_WINDOW, hi);
                write_reg(mppt_popi_pkg::CFG_COARSE_STEP, coarse);
                write_reg(mppt_popi_pkg::CFG_FINE_STEP, fine);
                write_reg(mppt_popi_pkg::CFG_PROP_GAIN, 16'($urandom_range(0, 65535)));
                write_reg(mppt_popi_pkg::CFG_INT_GAIN, 16'($urandom_range(0, 65535)));
            end
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    // panel sits near the reference on a knee-shaped curve
                    vi = int'(clamp(longint'(trk_reference)
                                    + longint'($urandom_range(0, 600)) - 300,
                                    0, VREF_HI));
                    if (vi <= KNEE_V)
                        ci = isc;
                    else if (vi >= OPEN_V)
                        ci = 0;
                    else
                        ci = isc * (OPEN_V - vi) / (OPEN_V - KNEE_V);
                    ci = int'(clamp(ci + int'($urandom_range(0, 40)) - 20, 0, VREF_HI));
                    send_tick(16'(vi), 16'(ci));
                end else begin
                    send_tick(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = mppt_popi_pkg::CFG_UPDATE_PERIOD;
        i_cfg_wdata     = '0;
        i_in_valid      = 1'b0;
        i_panel_voltage = '0;
        i_panel_current = '0;
        mismatch_count  = 0;
        gaps_enabled    = 1'b1;
        reg_period      = mppt_popi_pkg::RST_UPDATE_PERIOD;
        reg_lower       = mppt_popi_pkg::RST_LOWER_WINDOW;
        reg_upper       = mppt_popi_pkg::RST_UPPER_WINDOW;
        reg_coarse      = mppt_popi_pkg::RST_COARSE_STEP;
        reg_fine        = mppt_popi_pkg::RST_FINE_STEP;
        reg_kp          = mppt_popi_pkg::RST_PROP_GAIN;
        reg_ki          = mppt_popi_pkg::RST_INT_GAIN;
        trk_phase       = '0;
        trk_last_power  = '0;
        trk_last_volt   = '0;
        trk_reference   = '0;
        pi_integrator   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_reference_limits();
        test_update_period();
        test_gain_extremes();
        test_duty_saturation();
        test_random_tracking();
        settle();

        if (mismatch_count == 0)
            $display("tb_mppt_perturb_observe_pi: PASS");
        else
            $display("tb_mppt_perturb_observe_pi: FAIL");
        $finish;
    end

    // result receiver: per result, hold ready low for a random number of cycles
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            stall = gaps_enabled ? $urandom_range(0, 8) : 0;
            @(negedge i_clk);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                do @(posedge i_clk); while (!o_out_valid);
                repeat (stall - 1) @(posedge i_clk);
                @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_tick_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pi_results.size() == 0) begin
                report_mismatch("result transaction with no tick pending");
            end else begin
                want = pending_pi_results.pop_front();
                if (o_duty_command !== want.duty)
                    report_mismatch($sformatf("duty_command got %0d expected %0d",
                                              o_duty_command, want.duty));
                if (o_voltage_error !== want.verr)
                    report_mismatch($sformatf("voltage_error got %0d expected %0d",
                                              o_voltage_error, want.verr));
                if (o_voltage_reference !== want.vref)
                    report_mismatch($sformatf("voltage_reference got %0d expected %0d",
                                              o_voltage_reference, want.vref));
            end
        end
    end

    // run limit
    initial begin
        #20ms;
        $display("tb_mppt_perturb_observe_pi: FAIL");
        $finish;
    end

endmodule
